FILE: rtl/mavg_pkg.sv
package mavg_pkg;

	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned SEG_W     = 7;
	localparam int unsigned AVG_W     = 5;
	localparam int unsigned AVG_LIMIT = 20;

	localparam logic [WORD_W-1:0] BLANK_WORD = '1;
	localparam logic [3:0]        TAIL_BITS  = 4'hF;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [SEG_W-1:0]    seg_t;
	typedef logic [AVG_W-1:0]    avg_t;

	// active-low abcdefg, segment a in the MSB
	function automatic seg_t digit_seg(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'd0: s = 7'b0000001;
			4'd1: s = 7'b1001111;
			4'd2: s = 7'b0010010;
			4'd3: s = 7'b0000110;
			4'd4: s = 7'b1001100;
			4'd5: s = 7'b0100100;
			4'd6: s = 7'b0100000;
			4'd7: s = 7'b0001111;
			4'd8: s = 7'b0000000;
			4'd9: s = 7'b0000100;
			default: s = 7'b1111111;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/mavg_window.sv
module mavg_window #(
	parameter int unsigned WINDOW_LEN = 8,
	parameter int unsigned SUM_W      = 8 + $clog2(WINDOW_LEN)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  mavg_pkg::sample_t     sample,
	input  logic                  hold,
	output logic [SUM_W-1:0]      sum_q
);

	mavg_pkg::sample_t win_q [WINDOW_LEN];
	mavg_pkg::sample_t drop;
	logic [SUM_W-1:0]  sum_next;

	// running sum: add the new word, remove the one it displaces
	assign drop     = hold ? win_q[0] : win_q[WINDOW_LEN-1];
	assign sum_next = sum_q + SUM_W'(sample) - SUM_W'(drop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (load) begin
			sum_q    <= sum_next;
			win_q[0] <= sample;
			if (!hold) begin
				for (int i = 1; i < WINDOW_LEN; i++) begin
					win_q[i] <= win_q[i-1];
				end
			end
		end
	end

endmodule

FILE: rtl/mavg_decode.sv
module mavg_decode #(
	parameter int unsigned WINDOW_LEN = 8,
	parameter int unsigned SUM_W      = 8 + $clog2(WINDOW_LEN)
) (
	input  logic [SUM_W-1:0]  sum,
	output mavg_pkg::word_t   display_word
);

	localparam int unsigned NCMP = mavg_pkg::AVG_LIMIT + 1;

	logic [NCMP:1]   ge;
	logic [31:0]     sum_ext;
	mavg_pkg::avg_t  avg;
	logic [3:0]      tens;
	logic [3:0]      ones;

	assign sum_ext = 32'(sum);

	// floor(sum / WINDOW_LEN) >= k  <=>  sum >= k * WINDOW_LEN
	always_comb begin
		for (int k = 1; k <= NCMP; k++) begin
			ge[k] = sum_ext >= 32'(k * WINDOW_LEN);
		end
	end

	always_comb begin
		avg = '0;
		for (int k = 1; k < NCMP; k++) begin
			if (ge[k]) begin
				avg = mavg_pkg::avg_t'(k);
			end
		end
	end

	always_comb begin
		if (avg >= 5'd20) begin
			tens = 4'd2;
			ones = 4'(avg - 5'd20);
		end else if (avg >= 5'd10) begin
			tens = 4'd1;
			ones = 4'(avg - 5'd10);
		end else begin
			tens = 4'd0;
			ones = 4'(avg);
		end
	end

	assign display_word = ge[NCMP] ? mavg_pkg::BLANK_WORD :
		{mavg_pkg::digit_seg(ones), mavg_pkg::digit_seg(tens),
		 mavg_pkg::digit_seg(4'd0), mavg_pkg::digit_seg(4'd0), mavg_pkg::TAIL_BITS};

endmodule

FILE: rtl/moving_average_seven_segment.sv
// Moving average of the last WINDOW_LEN samples, shown on a seven-segment word.
// Input channel: sample, hold with sample_valid / sample_ready. hold clear shifts
// the window and the sample enters as newest; hold set overwrites the newest entry.
// Output channel: display_word with display_valid / display_ready. The word is
// active low: ones digit in 31:25, tens digit in 24:18, two zero digits below,
// 3:0 all ones; an average above twenty gives all ones.
// Throughput: one word per cycle unless the receiver stalls. The window and a
// running sum update at the accepting edge, then one stage of threshold compare
// and digit decode feeds the output register.
// Reset clears the window, the sum and both valid flags.
// When the receiver stalls, the output register holds its word and the middle
// stage keeps one more; sample_ready drops only when both are full.
module moving_average_seven_segment #(
	parameter int unsigned WINDOW_LEN = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  mavg_pkg::sample_t sample,
	input  logic              hold,
	output logic              display_valid,
	input  logic              display_ready,
	output mavg_pkg::word_t   display_word
);

	localparam int unsigned SUM_W = 8 + $clog2(WINDOW_LEN);

	logic             accept;
	logic             advance;
	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;
	mavg_pkg::word_t  word_d;
	mavg_pkg::word_t  word_q;
	logic             out_valid_q;

	assign advance      = valid_s1 && (!out_valid_q || display_ready);
	assign sample_ready = !valid_s1 || advance;
	assign accept       = sample_valid && sample_ready;

	mavg_window #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W     (SUM_W)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (accept),
		.sample(sample),
		.hold  (hold),
		.sum_q (sum_s1)
	);

	mavg_decode #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W     (SUM_W)
	) u_decode (
		.sum         (sum_s1),
		.display_word(word_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (display_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= word_d;
		end
	end

	assign display_valid = out_valid_q;
	assign display_word  = word_q;

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> valid_s1 && out_valid_q && !display_ready)
		else $error("input stalled while a stage is free");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word lost before the middle stage");

	a_move_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> display_valid)
		else $error("word left the middle stage but no result shown");

	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		display_valid |-> display_word[3:0] == mavg_pkg::TAIL_BITS)
		else $error("display tail bits not all ones");

endmodule
